// ===== sv/ggs_pkg.sv =====
`timescale 1ns / 1ps
package ggs_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int X_W     = COORD_W + 20;
    localparam int XF_W    = COORD_W + 3;
    localparam int Z_W     = 30;
    localparam int FRAC    = 16;
    localparam int PROD_W  = XF_W + 16;
    localparam int BEAR_W  = Z_W - FRAC;
    localparam int ERR_W   = 15;
    localparam int MULP_W  = 21;
    localparam int QUO_W   = 10;
    localparam int DIVR_W  = 11;
    localparam logic [15:0] INV_GAIN = 16'd39797;

    localparam logic [2:0] REG_DIST_TOL  = 3'd0;
    localparam logic [2:0] REG_ANGLE_TOL = 3'd1;
    localparam logic [2:0] REG_SLOW      = 3'd2;
    localparam logic [2:0] REG_TURN      = 3'd3;
    localparam logic [2:0] REG_FWD       = 3'd4;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_MOVING  = 2'd1;
    localparam logic [1:0] ST_REACHED = 2'd2;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [11:0]        heading;
    } t_in_word;

    typedef struct packed {
        logic signed [10:0] turn_drive;
        logic [9:0]         forward_drive;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_CORDIC, S_DIST, S_ERR, S_DIV, S_OUT
    } t_state;

    // arctangent of 2^-i in tenths of a degree, 16 fraction bits
    function automatic logic [24:0] atan_tab(input logic [4:0] idx);
        logic [24:0] v;
        unique case (idx)
            5'd0:  v = 25'd29491200;
            5'd1:  v = 25'd17409672;
            5'd2:  v = 25'd9198793;
            5'd3:  v = 25'd4669451;
            5'd4:  v = 25'd2343786;
            5'd5:  v = 25'd1173036;
            5'd6:  v = 25'd586661;
            5'd7:  v = 25'd293348;
            5'd8:  v = 25'd146676;
            5'd9:  v = 25'd73339;
            5'd10: v = 25'd36669;
            5'd11: v = 25'd18335;
            5'd12: v = 25'd9167;
            5'd13: v = 25'd4584;
            5'd14: v = 25'd2292;
            5'd15: v = 25'd1146;
            5'd16: v = 25'd573;
            5'd17: v = 25'd286;
            5'd18: v = 25'd143;
            5'd19: v = 25'd72;
            5'd20: v = 25'd36;
            5'd21: v = 25'd18;
            5'd22: v = 25'd9;
            5'd23: v = 25'd4;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ggs_cordic.sv =====
`timescale 1ns / 1ps
module ggs_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ggs_pkg::DIFF_W-1:0]   i_dx,
    input  logic signed [ggs_pkg::DIFF_W-1:0]   i_dy,
    output logic                                o_done,
    output logic [ggs_pkg::XF_W-1:0]            o_mag,
    output logic signed [ggs_pkg::Z_W-1:0]      o_angle
);
    import ggs_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS + 1);

    logic signed [X_W-1:0] r_x, r_y, n_x, n_y, xs, ys, x0, y0;
    logic signed [Z_W-1:0] r_z, n_z, tab;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;

    assign x0  = X_W'(i_dx) <<< FRAC;
    assign y0  = X_W'(i_dy) <<< FRAC;
    assign xs  = r_x >>> r_cnt;
    assign ys  = r_y >>> r_cnt;
    assign tab = Z_W'(atan_tab(5'(r_cnt)));

    always_comb begin
        if (!r_y[X_W-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + tab;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - tab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(CORDIC_STEPS - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // pre-rotate by half a turn when the vector points backwards
            if (i_dx < 0) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= (i_dy >= 0) ? Z_W'(1800 * 65536) : -Z_W'(1800 * 65536);
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done  = r_busy && (r_cnt == CW'(CORDIC_STEPS - 1));
    assign o_mag   = r_x[X_W-1] ? '0 : r_x[FRAC +: XF_W];
    assign o_angle = r_z;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < CW'(CORDIC_STEPS)) else $error("cordic count overrun");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_start |=> !r_busy) else $error("cordic runs past done");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_cnt == '0) else $error("cordic start lost");
`endif
endmodule

// ===== sv/ggs_div.sv =====
`timescale 1ns / 1ps
module ggs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ggs_pkg::MULP_W-1:0]       i_dividend,
    input  logic [ggs_pkg::DIVR_W-1:0]       i_divisor,
    output logic                             o_done,
    output logic [ggs_pkg::QUO_W-1:0]        o_quot
);
    import ggs_pkg::*;

    logic [MULP_W-1:0] r_q;
    logic [DIVR_W-1:0] r_rem, r_div;
    logic [DIVR_W:0]   rem_sh;
    logic              fits;
    logic [4:0]        r_cnt;
    logic              r_busy;

    // one quotient bit a cycle, dividend shifts out as quotient shifts in
    assign rem_sh = {r_rem, r_q[MULP_W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 5'(MULP_W - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[MULP_W-2:0], fits};
            r_rem <= fits ? DIVR_W'(rem_sh - {1'b0, r_div}) : rem_sh[DIVR_W-1:0];
        end
    end

    // the last quotient bit is still being decided on the done cycle
    assign o_done = r_busy && (r_cnt == 5'(MULP_W - 1));
    assign o_quot = {r_q[QUO_W-2:0], fits};

`ifndef ASSERT_OFF
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != '0 |-> r_rem < r_div) else $error("remainder not reduced");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_start |=> !r_busy) else $error("divider runs past done");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider start lost");
`endif
endmodule

// ===== sv/go_to_goal_steering.sv =====
`timescale 1ns / 1ps
// Go-to-goal steering. A goal word, or a pose word while the block is idle, goes straight
// to the output state; a pose word in motion first passes through the prep, CORDIC,
// distance and error states, with the one-iteration-a-cycle CORDIC that finds bearing and
// distance, and then the bit-serial divider that scales forward speed, one quotient bit a
// cycle; when the goal is reached or the slow angle is zero the divider is skipped.
// One word is worked on at a time; the input stalls until the result sits in the
// output register, and a finished result may wait there while the next word is accepted.
module go_to_goal_steering #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ggs_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ggs_pkg::t_out_word  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data
);
    import ggs_pkg::*;

    t_state r_state, n_state;

    logic [11:0] r_dtol;
    logic [10:0] r_atol, r_slow;
    logic [9:0]  r_tspd, r_fspd;

    logic signed [COORD_W-1:0] r_gx, r_gy, r_px, r_py;
    logic signed [11:0]        r_hd;
    logic                      r_moving;
    t_out_word                 r_res, r_out;
    logic                      r_out_valid;

    logic signed [DIFF_W-1:0] dx, dy, adx, ady;
    logic                     cordic_start, cordic_done, div_start, div_done;
    logic [XF_W-1:0]          cmag;
    logic signed [Z_W-1:0]    cang;
    logic [QUO_W-1:0]         quot;
    logic [PROD_W-1:0]        r_prod, prod_rnd;
    logic [PROD_W-17:0]       dist_mm;
    logic signed [Z_W-1:0]    zr;
    logic signed [BEAR_W-1:0] bearing;
    logic signed [ERR_W-1:0]  err_raw, err;
    logic [ERR_W-1:0]         aerr;
    logic [10:0]              amin;
    logic [MULP_W-1:0]        mulp;
    logic                     accept, take_out, reached, out_free;

    assign accept      = i_in_valid && !o_in_stall;
    assign take_out    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtol <= 12'd100;
            r_atol <= 11'd20;
            r_slow <= 11'd300;
            r_tspd <= 10'd500;
            r_fspd <= 10'd300;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DIST_TOL:  r_dtol <= i_cfg_data;
                REG_ANGLE_TOL: r_atol <= i_cfg_data[10:0];
                REG_SLOW:      r_slow <= i_cfg_data[10:0];
                REG_TURN:      r_tspd <= i_cfg_data[9:0];
                REG_FWD:       r_fspd <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // per-axis differences, zeroed inside the tolerance
    always_comb begin
        dx  = DIFF_W'(r_gx) - DIFF_W'(r_px);
        dy  = DIFF_W'(r_gy) - DIFF_W'(r_py);
        adx = dx[DIFF_W-1] ? -dx : dx;
        ady = dy[DIFF_W-1] ? -dy : dy;
        if ($unsigned(adx) < DIFF_W'(r_dtol)) dx = '0;
        if ($unsigned(ady) < DIFF_W'(r_dtol)) dy = '0;
    end

    ggs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_done  (cordic_done),
        .o_mag   (cmag),
        .o_angle (cang)
    );

    assign prod_rnd = r_prod + PROD_W'(32768);
    assign dist_mm  = prod_rnd[PROD_W-1:16];
    assign reached  = dist_mm <= (PROD_W - 16)'(r_dtol);
    assign zr       = cang + Z_W'(32768);
    assign bearing  = zr[Z_W-1:FRAC];

    always_comb begin
        err_raw = ERR_W'(bearing) - ERR_W'(r_hd);
        if (err_raw >= ERR_W'(1800))       err = err_raw - ERR_W'(3600);
        else if (err_raw <= -ERR_W'(1800)) err = err_raw + ERR_W'(3600);
        else                               err = err_raw;
        aerr = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        amin = (aerr > ERR_W'(r_slow)) ? r_slow : aerr[10:0];
    end

    assign mulp = MULP_W'(r_fspd) * MULP_W'(r_slow - amin);

    ggs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mulp),
        .i_divisor  (r_slow),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = (i_in_data.cmd && r_moving) ? S_PREP : S_OUT;
            S_PREP:   n_state = S_CORDIC;
            S_CORDIC: if (cordic_done) n_state = S_DIST;
            S_DIST:   n_state = S_ERR;
            S_ERR:    n_state = (reached || r_slow == '0) ? S_OUT : S_DIV;
            S_DIV:    if (div_done) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = r_state != S_IDLE;
        cordic_start = r_state == S_PREP;
        div_start    = (r_state == S_ERR) && !reached && (r_slow != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_moving    <= 1'b0;
            r_gx        <= '0;
            r_gy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && !i_in_data.cmd) begin
                r_gx     <= i_in_data.pos_x;
                r_gy     <= i_in_data.pos_y;
                r_moving <= 1'b1;
            end
            if (r_state == S_ERR && reached) r_moving <= 1'b0;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (take_out)                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= i_in_data.pos_x;
            r_py <= i_in_data.pos_y;
            r_hd <= i_in_data.heading;
            r_res.turn_drive    <= '0;
            r_res.forward_drive <= '0;
            r_res.status        <= !i_in_data.cmd ? ST_MOVING :
                                   (r_moving ? ST_MOVING : ST_IDLE);
        end
        if (r_state == S_DIST) r_prod <= PROD_W'(cmag) * INV_GAIN;
        if (r_state == S_ERR) begin
            if (reached) begin
                r_res.status <= ST_REACHED;
            end else if (aerr > ERR_W'(r_atol)) begin
                r_res.turn_drive <= err[ERR_W-1] || err == '0 ? -11'(r_tspd) : 11'(r_tspd);
            end
        end
        if (r_state == S_DIV && div_done) r_res.forward_drive <= quot;
        if (r_state == S_OUT && out_free) r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_reached_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_MOVING |->
        o_out_data.turn_drive == '0 && o_out_data.forward_drive == '0)
        else $error("drive given while not in motion");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status != 2'd3) else $error("bad status code");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall) else $error("second word taken while busy");
`endif
endmodule
